// ===== src/assert_macros.svh =====
// Assertion macros used by the decoder back end.
// Active unless SYNTH is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== src/simd_pkg.sv =====
// Types and codes for the shaft index and mark decoder.
// No dependencies.
`timescale 1ns / 1ps
package simd_pkg;
  localparam int unsigned NUM_REGS = 8;
  localparam logic [2:0] REG_NOMINAL = 3'd0;
  localparam logic [2:0] REG_WINDOW  = 3'd1;
  localparam logic [2:0] REG_CD      = 3'd2;
  localparam logic [2:0] REG_RST     = 3'd3;
  localparam logic [2:0] REG_INIT    = 3'd4;
  localparam logic [2:0] REG_REJECT  = 3'd5;
  localparam logic [2:0] REG_MIN     = 3'd6;
  localparam logic [2:0] REG_MAX     = 3'd7;

  localparam logic [2:0] MK_NONE       = 3'd0;
  localparam logic [2:0] MK_COUNT_UP   = 3'd1;
  localparam logic [2:0] MK_COUNT_DOWN = 3'd2;

  localparam logic [2:0] FLT_NONE          = 3'd0;
  localparam logic [2:0] FLT_INDEX_MISSING = 3'd1;
  localparam logic [2:0] FLT_UNEXPECTED    = 3'd2;
  localparam logic [2:0] FLT_DUPLICATE     = 3'd3;
  localparam logic [2:0] FLT_TOO_FAST      = 3'd4;
  localparam logic [2:0] FLT_TOO_SLOW      = 3'd5;

  typedef struct packed {
    logic [31:0] sample_time;
    logic        index_on;
    logic        mark_on;
  } sample_t;

  typedef struct packed {
    logic [2:0]  recognised_mark;
    logic        in_sync;
    logic [2:0]  fault_code;
    logic [15:0] angle_centideg;
    logic [31:0] measured_revolution;
    logic [31:0] revolution_total;
    logic [2:0]  latest_mark;
    logic [31:0] latest_mark_time;
  } result_t;

  // Classified sample handed from front to back.
  typedef struct packed {
    logic [31:0] now;
    logic        index_rise;
    logic        mark_rise;
  } event_t;

  typedef struct packed {
    logic [31:0] nominal;
    logic [15:0] window;
    logic [31:0] cd;
    logic [31:0] rst_off;
    logic [31:0] init_off;
    logic [31:0] reject_off;
    logic [31:0] min_rev;
    logic [31:0] max_rev;
  } cfg_t;
endpackage

// ===== src/simd_divider.sv =====
// Serial restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// Depends on nothing.
`timescale 1ns / 1ps
module simd_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  logic [63:0] quo;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [6:0]  count;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[63]} - {1'b0, dvs};
  assign quotient = quo;

  // Shift one quotient bit per cycle while busy
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= 7'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 7'd0;
        quo <= dividend;
        rem <= 33'd0;
        dvs <= divisor;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[31:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        count <= count + 7'd1;
        if (count == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== src/simd_front.sv =====
// Front end: edge detection and debounce of the index and mark sensors.
// Depends on simd_pkg.
`timescale 1ns / 1ps
module simd_front #(
  parameter int unsigned DEBOUNCE_TIME = 1000
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  simd_pkg::sample_t in_data,
  output simd_pkg::event_t  ev
);
  import simd_pkg::*;
  logic        index_prev, mark_prev;
  logic [31:0] index_edge_time, mark_edge_time;
  logic        ie, me;

  always_comb begin
    ie = in_data.index_on && !index_prev &&
         ((in_data.sample_time - index_edge_time) >= 32'(DEBOUNCE_TIME));
    me = in_data.mark_on && !mark_prev &&
         ((in_data.sample_time - mark_edge_time) >= 32'(DEBOUNCE_TIME));
    ev.now = in_data.sample_time;
    ev.index_rise = ie;
    ev.mark_rise = me;
  end

  // Advance edge history on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      index_prev <= 1'b0;
      mark_prev <= 1'b0;
      index_edge_time <= 32'd0;
      mark_edge_time <= 32'd0;
    end else if (in_valid) begin
      index_prev <= in_data.index_on;
      mark_prev <= in_data.mark_on;
      if (ie) index_edge_time <= in_data.sample_time;
      if (me) mark_edge_time <= in_data.sample_time;
    end
  end
endmodule

// ===== src/simd_back.sv =====
// Back end: revolution measurement, mark classification and angle tracking.
// Depends on simd_pkg and simd_divider.
`timescale 1ns / 1ps
module simd_back (
  input  logic              clk,
  input  logic              rst,
  input  simd_pkg::cfg_t    cfg,
  input  logic              ev_valid,
  input  simd_pkg::event_t  ev_in,
  output logic              ev_ready,
  output logic              res_valid,
  output simd_pkg::result_t res,
  input  logic              res_ready
);
  import simd_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_INDEX = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_WAIT  = 7'b0001000,
    S_CMP   = 7'b0010000,
    S_ANG   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t      state;
  event_t      ev;
  logic [2:0]  k;
  logic        found;
  logic [2:0]  match;
  logic        div_phase;
  logic [63:0] expected;

  logic [5:0]  seen_marks;
  logic        index_valid, sync_flag;
  logic [31:0] revolution_period, revolution_counter, index_time, last_mark_time;
  logic [2:0]  fault_state, last_mark_kind, recognised;
  logic [15:0] angle_value;

  logic        div_start, div_done;
  logic [63:0] div_a, div_q;
  logic [31:0] div_b;

  simd_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a),
    .divisor(div_b), .done(div_done), .quotient(div_q)
  );

  logic [31:0] rev, since, since_c, offs;
  logic [47:0] window;
  logic [31:0] nom_k;
  logic [64:0] lo, hi;
  logic [16:0] centi_sum;

  always_comb begin
    rev = (revolution_period != 32'd0) ? revolution_period : cfg.nominal;
    window = (48'(rev) * 48'(cfg.window)) >> 16;
    offs = ev.now - index_time;
    since = ev.now - index_time;
    since_c = (since > revolution_period) ? revolution_period : since;
    case (k)
      3'd0:    nom_k = cfg.cd;
      3'd1:    nom_k = cfg.rst_off;
      3'd2:    nom_k = cfg.init_off;
      default: nom_k = cfg.reject_off;
    endcase
    lo = (expected > 64'(window)) ? 65'(expected - 64'(window)) : 65'd0;
    hi = 65'(expected) + 65'(window);
    centi_sum = 17'd31500 + 17'(div_q[15:0]);
    div_start = 1'b0;
    div_a = 64'(nom_k) * 64'(rev);
    div_b = cfg.nominal;
    if (state == S_DIV && !div_phase && cfg.nominal != 32'd0) div_start = 1'b1;
    if (state == S_ANG && !div_phase) begin
      div_start = 1'b1;
      div_a = 64'(since_c) * 64'd36000;
      div_b = revolution_period;
    end
  end

  assign ev_ready = (state == S_IDLE);
  assign res_valid = (state == S_OUT);
  assign res = '{recognised_mark: recognised, in_sync: sync_flag, fault_code: fault_state,
                 angle_centideg: angle_value, measured_revolution: revolution_period,
                 revolution_total: revolution_counter, latest_mark: last_mark_kind,
                 latest_mark_time: last_mark_time};

  // Sequence one event through index, marks, timeout and angle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      seen_marks <= 6'd0;
      index_valid <= 1'b0;
      revolution_period <= 32'd0;
      sync_flag <= 1'b0;
      fault_state <= FLT_NONE;
      revolution_counter <= 32'd0;
      index_time <= 32'd0;
      last_mark_kind <= MK_NONE;
      last_mark_time <= 32'd0;
      angle_value <= 16'd0;
      recognised <= MK_NONE;
      k <= 3'd0;
      div_phase <= 1'b0;
      found <= 1'b0;
      match <= MK_NONE;
      expected <= 64'd0;
    end else begin
      case (state)
        S_IDLE: if (ev_valid) begin
          ev <= ev_in;
          recognised <= MK_NONE;
          state <= S_INDEX;
        end
        S_INDEX: begin
          if (ev.index_rise) begin
            if (index_valid) begin
              if (ev.now - index_time < cfg.min_rev) begin
                fault_state <= FLT_TOO_FAST; sync_flag <= 1'b0;
              end else if (ev.now - index_time > cfg.max_rev) begin
                fault_state <= FLT_TOO_SLOW; sync_flag <= 1'b0;
              end else begin
                revolution_period <= ev.now - index_time;
                sync_flag <= 1'b1;
                fault_state <= FLT_NONE;
                revolution_counter <= revolution_counter + 32'd1;
              end
            end
            index_valid <= 1'b1;
            index_time <= ev.now;
            last_mark_kind <= MK_COUNT_UP;
            last_mark_time <= ev.now;
            seen_marks <= 6'd0;
            recognised <= MK_COUNT_UP;
          end
          k <= 3'd0;
          found <= 1'b0;
          div_phase <= 1'b0;
          if (ev.mark_rise && !(index_valid || ev.index_rise)) begin
            fault_state <= FLT_INDEX_MISSING;
            state <= S_ANG;
          end else if (ev.mark_rise) state <= S_DIV;
          else state <= S_ANG;
        end
        S_DIV: begin
          if (cfg.nominal == 32'd0) begin
            expected <= 64'(nom_k);
            state <= S_CMP;
          end else begin
            div_phase <= 1'b1;
            state <= S_WAIT;
          end
        end
        S_WAIT: if (div_done) begin
          expected <= div_q;
          div_phase <= 1'b0;
          state <= S_CMP;
        end
        S_CMP: begin
          if (!found && 65'(offs) >= lo && 65'(offs) <= hi) begin
            found <= 1'b1;
            match <= MK_COUNT_DOWN + k;
          end
          if (k == 3'd3) begin
            state <= S_ANG;
            k <= 3'd0;
            div_phase <= 1'b0;
            if (!found && !(65'(offs) >= lo && 65'(offs) <= hi)) begin
              fault_state <= FLT_UNEXPECTED; sync_flag <= 1'b0;
            end else begin
              logic [2:0] m;
              m = found ? match : (MK_COUNT_DOWN + k);
              if (seen_marks[m]) begin
                fault_state <= FLT_DUPLICATE; sync_flag <= 1'b0;
              end else begin
                seen_marks[m] <= 1'b1;
                last_mark_kind <= m;
                last_mark_time <= ev.now;
                recognised <= m;
              end
            end
          end else begin
            k <= k + 3'd1;
            state <= S_DIV;
          end
        end
        S_ANG: begin
          if (!div_phase) begin
            if (index_valid && since > cfg.max_rev) begin
              fault_state <= FLT_INDEX_MISSING; sync_flag <= 1'b0;
              state <= S_OUT;
            end else if (sync_flag && revolution_period != 32'd0) begin
              div_phase <= 1'b1;
            end else state <= S_OUT;
          end else if (div_done) begin
            angle_value <= (centi_sum >= 17'd36000) ? 16'(centi_sum - 17'd36000)
                                                    : centi_sum[15:0];
            div_phase <= 1'b0;
            state <= S_OUT;
          end
        end
        S_OUT: if (res_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_ready_idle, clk, rst, ev_ready, !res_valid)
  `ASSERT_IMPL(a_hold_out, clk, rst, res_valid && !res_ready, ##1 res_valid)
  `ASSERT_NEVER(a_seen_low, clk, rst, seen_marks[1:0] != 2'b00)
endmodule

// ===== src/simd_queue.sv =====
// Two-entry queue for events or results between the decoder parts.
// Depends on nothing.
`timescale 1ns / 1ps
module simd_queue #(
  parameter int unsigned WIDTH = 34
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  logic [WIDTH-1:0] mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  assign full = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign rdata = mem[rp];
  // Advance pointers per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (wr && !full) begin
        wp <= ~wp;
      end
      if (rd && !empty) rp <= ~rp;
      cnt <= cnt + 2'(wr && !full) - 2'(rd && !empty);
    end
  end
  always_ff @(posedge clk) begin
    if (wr && !full) mem[wp] <= wdata;
  end
endmodule

// ===== src/shaft_index_mark_decoder.sv =====
// Shaft index and mark decoder. Each sample is debounced and edge-detected in
// the front end, queued, then processed in the back end one event at a time;
// that processing is set by the bit-serial 64-bit divider, which runs up to four
// offset scalings on a mark edge and up to one angle division. Results wait in
// a two-entry output queue. No clearing pass.
`timescale 1ns / 1ps
module shaft_index_mark_decoder #(
  parameter int unsigned DEBOUNCE_TIME = 1000
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  simd_pkg::sample_t sample,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output simd_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import simd_pkg::*;
  cfg_t    cfg;
  event_t  ev, qev;
  logic    qfull, qempty, bready, bvalid, ofull;
  result_t bres;

  assign cfg_ready = 1'b1;
  assign full = qfull;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{nominal: 32'd1000000, window: 16'd3277, cd: 32'd0, rst_off: 32'd0,
               init_off: 32'd0, reject_off: 32'd0, min_rev: 32'd500000,
               max_rev: 32'd2000000};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NOMINAL: cfg.nominal <= cfg_data;
        REG_WINDOW:  cfg.window <= cfg_data[15:0];
        REG_CD:      cfg.cd <= cfg_data;
        REG_RST:     cfg.rst_off <= cfg_data;
        REG_INIT:    cfg.init_off <= cfg_data;
        REG_REJECT:  cfg.reject_off <= cfg_data;
        REG_MIN:     cfg.min_rev <= cfg_data;
        default:     cfg.max_rev <= cfg_data;
      endcase
    end
  end

  simd_front #(.DEBOUNCE_TIME(DEBOUNCE_TIME)) u_front (
    .clk(clk), .rst(rst), .in_valid(push && !qfull), .in_data(sample), .ev(ev)
  );

  simd_queue #(.WIDTH($bits(event_t))) u_evq (
    .clk(clk), .rst(rst), .wr(push), .wdata(ev), .full(qfull),
    .rd(bready), .rdata(qev), .empty(qempty)
  );

  simd_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .ev_valid(!qempty), .ev_in(qev),
    .ev_ready(bready), .res_valid(bvalid), .res(bres), .res_ready(!ofull)
  );

  simd_queue #(.WIDTH($bits(result_t))) u_resq (
    .clk(clk), .rst(rst), .wr(bvalid), .wdata(bres), .full(ofull),
    .rd(pop), .rdata(result), .empty(empty)
  );
endmodule

// ===== verif/shaft_index_mark_decoder_tb.sv =====
// Testbench for shaft_index_mark_decoder: queue-fed driver, result monitor and
// an item-level behavioral predictor of the decoder. Depends on simd_pkg and the decoder.
`timescale 1ns / 1ps
module shaft_index_mark_decoder_tb;
  import simd_pkg::*;

  localparam int unsigned BOUNCE_GAP = 1000;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned SETTLE_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  sample_t     sample = '0;
  logic        full;
  logic        empty;
  logic        pop = 1'b0;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  shaft_index_mark_decoder dut (
    .clk(clk), .rst(rst), .push(push), .sample(sample), .full(full),
    .empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  sample_t     pending_samples[$];
  result_t     expected_results[$];
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  bit          beat_taken = 1'b0;

  // Predictor copy of registers and decoder state
  logic [31:0] cfg_regs[NUM_REGS];
  logic        p_index_prev, p_mark_prev, p_index_valid, p_sync;
  logic [31:0] p_index_edge_time, p_mark_edge_time, p_period, p_rev_count;
  logic [31:0] p_index_time, p_last_mark_time;
  logic [5:0]  p_seen;
  logic [2:0]  p_fault, p_last_mark;
  logic [15:0] p_angle;

  function automatic void reset_predictor();
    cfg_regs[REG_NOMINAL] = 32'd1000000;
    cfg_regs[REG_WINDOW]  = 32'd3277;
    cfg_regs[REG_CD]      = '0;
    cfg_regs[REG_RST]     = '0;
    cfg_regs[REG_INIT]    = '0;
    cfg_regs[REG_REJECT]  = '0;
    cfg_regs[REG_MIN]     = 32'd500000;
    cfg_regs[REG_MAX]     = 32'd2000000;
    p_index_prev = 0; p_mark_prev = 0; p_index_valid = 0; p_sync = 0;
    p_index_edge_time = '0; p_mark_edge_time = '0; p_period = '0;
    p_rev_count = '0; p_index_time = '0; p_last_mark_time = '0;
    p_seen = '0; p_fault = FLT_NONE; p_last_mark = MK_NONE; p_angle = '0;
  endfunction

  // Match a mark offset against the scaled expected offsets, first hit wins
  function automatic logic [2:0] match_mark(logic [31:0] offset);
    logic [63:0] nom, rev, win, want, lo, hi;
    nom = {32'd0, cfg_regs[REG_NOMINAL]};
    rev = (p_period != 0) ? {32'd0, p_period} : nom;
    win = (rev * {48'd0, cfg_regs[REG_WINDOW][15:0]}) >> 16;
    for (int k = 0; k < 4; k++) begin
      want = {32'd0, cfg_regs[REG_CD + k]};
      if (nom != 0) want = (want * rev) / nom;
      lo = (want > win) ? want - win : 64'd0;
      hi = want + win;
      if ({32'd0, offset} >= lo && {32'd0, offset} <= hi) return MK_COUNT_DOWN + 3'(k);
    end
    return MK_NONE;
  endfunction

  function automatic result_t decode_sample(sample_t s);
    result_t     r;
    logic [31:0] now, rev, since;
    logic [63:0] centi;
    logic [2:0]  m;
    logic        index_rise, mark_rise;
    now = s.sample_time;
    index_rise = s.index_on && !p_index_prev;
    mark_rise = s.mark_on && !p_mark_prev;
    p_index_prev = s.index_on;
    p_mark_prev = s.mark_on;
    r = '0;
    r.recognised_mark = MK_NONE;
    // Index edge: measure revolution and restart
    if (index_rise && (now - p_index_edge_time) >= BOUNCE_GAP) begin
      p_index_edge_time = now;
      if (p_index_valid) begin
        rev = now - p_index_time;
        if (rev < cfg_regs[REG_MIN]) begin
          p_fault = FLT_TOO_FAST; p_sync = 0;
        end else if (rev > cfg_regs[REG_MAX]) begin
          p_fault = FLT_TOO_SLOW; p_sync = 0;
        end else begin
          p_period = rev; p_sync = 1; p_fault = FLT_NONE;
          p_rev_count = p_rev_count + 1;
        end
      end
      p_index_valid = 1;
      p_index_time = now;
      p_last_mark = MK_COUNT_UP;
      p_last_mark_time = now;
      p_seen = '0;
      r.recognised_mark = MK_COUNT_UP;
    end
    // Mark edge: classify against the window
    if (mark_rise && (now - p_mark_edge_time) >= BOUNCE_GAP) begin
      p_mark_edge_time = now;
      if (!p_index_valid) begin
        p_fault = FLT_INDEX_MISSING;
      end else begin
        m = match_mark(now - p_index_time);
        if (m == MK_NONE) begin
          p_fault = FLT_UNEXPECTED; p_sync = 0;
        end else if (p_seen[m]) begin
          p_fault = FLT_DUPLICATE; p_sync = 0;
        end else begin
          p_seen[m] = 1'b1;
          p_last_mark = m;
          p_last_mark_time = now;
          r.recognised_mark = m;
        end
      end
    end
    // Index timeout
    if (p_index_valid && (now - p_index_time) > cfg_regs[REG_MAX]) begin
      p_fault = FLT_INDEX_MISSING; p_sync = 0;
    end
    // Track angle while in sync
    if (p_sync && p_period != 0) begin
      since = now - p_index_time;
      if (since > p_period) since = p_period;
      centi = ({32'd0, since} * 64'd36000) / {32'd0, p_period};
      p_angle = 16'((64'd31500 + centi) % 64'd36000);
    end
    r.in_sync = p_sync;
    r.fault_code = p_fault;
    r.angle_centideg = p_angle;
    r.measured_revolution = p_period;
    r.revolution_total = p_rev_count;
    r.latest_mark = p_last_mark;
    r.latest_mark_time = p_last_mark_time;
    return r;
  endfunction

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("shaft_index_mark_decoder test failed");
      $finish;
    end
  end

  // Accept input beats and predict their results
  always @(posedge clk) begin
    beat_taken = 1'b0;
    if (!rst && push && !full) begin
      beat_taken = 1'b1;
      expected_results.push_back(decode_sample(sample));
    end
  end

  // Drive samples, hold a beat until taken
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (push && !beat_taken) begin
      push <= 1'b1;
    end else if (pending_samples.size() != 0 &&
                 $urandom_range(99) >= sender_idle_pct) begin
      sample <= pending_samples.pop_front();
      push <= 1'b1;
    end else begin
      push <= 1'b0;
    end
  end

  // Check result beats against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && pop && !empty) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (want !== result) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, result);
          if (want.recognised_mark !== result.recognised_mark)
            $display("  recognised_mark exp %0d act %0d", want.recognised_mark,
                     result.recognised_mark);
          if (want.in_sync !== result.in_sync)
            $display("  in_sync exp %0d act %0d", want.in_sync, result.in_sync);
          if (want.fault_code !== result.fault_code)
            $display("  fault_code exp %0d act %0d", want.fault_code, result.fault_code);
          if (want.angle_centideg !== result.angle_centideg)
            $display("  angle exp %0d act %0d", want.angle_centideg, result.angle_centideg);
          if (want.measured_revolution !== result.measured_revolution)
            $display("  period exp %0d act %0d", want.measured_revolution,
                     result.measured_revolution);
          if (want.revolution_total !== result.revolution_total)
            $display("  total exp %0d act %0d", want.revolution_total,
                     result.revolution_total);
          if (want.latest_mark !== result.latest_mark)
            $display("  latest_mark exp %0d act %0d", want.latest_mark, result.latest_mark);
          if (want.latest_mark_time !== result.latest_mark_time)
            $display("  latest_mark_time exp %0d act %0d", want.latest_mark_time,
                     result.latest_mark_time);
          error_count++;
        end
      end
    end
  end

  // Drive pop, with a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  task automatic queue_sample(logic [31:0] t, logic il, logic ml);
    sample_t s;
    s.sample_time = t;
    s.index_on = il;
    s.mark_on = ml;
    pending_samples.push_back(s);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_regs[idx] = (idx == REG_WINDOW) ? {16'd0, value[15:0]} : value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] nom, logic [31:0] win, logic [31:0] cd,
                           logic [31:0] rs, logic [31:0] ini, logic [31:0] rej,
                           logic [31:0] mn, logic [31:0] mx);
    write_reg(REG_NOMINAL, nom);
    write_reg(REG_WINDOW, win);
    write_reg(REG_CD, cd);
    write_reg(REG_RST, rs);
    write_reg(REG_INIT, ini);
    write_reg(REG_REJECT, rej);
    write_reg(REG_MIN, mn);
    write_reg(REG_MAX, mx);
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || push || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Queue revolutions with random content, plus some noise samples
  task automatic queue_revolutions(int unsigned count);
    logic [31:0] tcur, off, jitter;
    logic [63:0] nom, per, lo, hi;
    int unsigned added;
    tcur = $urandom;
    added = 0;
    nom = {32'd0, cfg_regs[REG_NOMINAL]};
    while (added < count) begin
      if ($urandom_range(99) < 15) begin
        // noise: random levels, time near now or anywhere
        queue_sample(($urandom_range(1) != 0) ? $urandom : tcur + $urandom_range(5000),
                     1'($urandom), 1'($urandom));
        added++;
        continue;
      end
      lo = {32'd0, cfg_regs[REG_MIN]};
      hi = {32'd0, cfg_regs[REG_MAX]};
      if ($urandom_range(99) < 80 && hi >= lo)
        per = lo + (((hi - lo) * $urandom_range(1000)) / 1000);
      else
        per = $urandom;
      if (per == 0) per = 1;
      if ($urandom_range(99) < 95) begin
        queue_sample(tcur, 1'b1, 1'b0);
        queue_sample(tcur + 200, 1'b0, 1'b0);
        added += 2;
      end
      for (int k = 0; k < 4; k++) begin
        if ($urandom_range(99) < 85) begin
          off = cfg_regs[REG_CD + k];
          if (nom != 0) off = 32'(({32'd0, off} * per) / nom);
          jitter = 32'((per * cfg_regs[REG_WINDOW][15:0]) >> 17);
          off = off + $urandom_range(jitter) - (jitter >> 1);
          queue_sample(tcur + off, 1'b0, 1'b1);
          queue_sample(tcur + off + 300, 1'b0, 1'b0);
          added += 2;
        end
      end
      if ($urandom_range(99) < 30) begin
        queue_sample(tcur + 32'(per * $urandom_range(100) / 100), 1'b0, 1'b0);
        added++;
      end
      tcur = tcur + 32'(per);
    end
  endtask

  initial begin
    reset_predictor();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Zero nominal period: rev is 0 until a revolution is accepted
    write_reg(REG_NOMINAL, 32'd0);
    queue_sample(32'd500, 1'b1, 1'b0);     // bounce after reset
    queue_sample(32'd600, 1'b0, 1'b0);
    queue_sample(32'd2000, 1'b0, 1'b1);    // mark before any index
    queue_sample(32'd2100, 1'b0, 1'b0);
    queue_sample(32'd5000, 1'b1, 1'b1);    // index and mark together
    queue_sample(32'd5100, 1'b0, 1'b0);
    queue_sample(32'd7000, 1'b0, 1'b1);    // outside zero window
    queue_sample(32'd7100, 1'b0, 1'b0);
    wait_idle();

    write_reg(REG_NOMINAL, 32'd1000000);
    queue_sample(32'd600000, 1'b1, 1'b0);
    queue_sample(32'd600100, 1'b0, 1'b0);
    queue_sample(32'd601500, 1'b0, 1'b1);
    queue_sample(32'd601600, 1'b0, 1'b0);
    queue_sample(32'd603000, 1'b0, 1'b1);  // duplicate
    queue_sample(32'd603100, 1'b0, 1'b0);
    queue_sample(32'd900000, 1'b0, 1'b0);
    queue_sample(32'd1000000, 1'b1, 1'b0); // too fast
    queue_sample(32'd1000100, 1'b0, 1'b0);
    queue_sample(32'd3500000, 1'b0, 1'b0); // index timeout
    queue_sample(32'd3600000, 1'b1, 1'b0); // too slow
    queue_sample(32'd3600100, 1'b0, 1'b0);
    queue_sample(32'hFFFF_FF00, 1'b1, 1'b0);
    queue_sample(32'hFFFF_FF80, 1'b0, 1'b0);
    queue_sample(32'h0008_0000, 1'b1, 1'b1); // wrapped revolution
    queue_sample(32'h0008_0100, 1'b0, 1'b0);
    wait_idle();

    // Sender idles rarely, receiver often; one long receiver hold-off
    sender_idle_pct = 8;
    receiver_idle_pct = 51;
    write_all(32'd100000, 32'd3277, 32'd20000, 32'd40000, 32'd60000, 32'd80000,
              32'd80000, 32'd120000);
    stall_left = 4000;
    queue_revolutions(330);
    wait_idle();

    // Extremes: largest values, window register with upper bits set
    sender_idle_pct = 51;
    receiver_idle_pct = 8;
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1000000000, 32'd2000000000,
              32'd3000000000, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    queue_revolutions(330);
    wait_idle();

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    write_all(32'd50000, 32'd8000, 32'd5000, 32'd15000, 32'd30000, 32'd45000,
              32'd40000, 32'd60000);
    queue_revolutions(450);
    wait_idle();

    // Extremes: smallest values, inverted revolution limits
    write_all(32'd0, 32'd0, 32'd0, 32'd2000, 32'd4000, 32'd6000,
              32'hFFFF_FFFF, 32'd0);
    queue_revolutions(220);
    wait_idle();

    if (error_count == 0)
      $display("shaft_index_mark_decoder test passed");
    else
      $display("shaft_index_mark_decoder test failed");
    $finish;
  end
endmodule
